### design/mxp_pkg.sv
// Shared types, register indexes and float compare for the max pooling block.
`default_nettype none
package mxp_pkg;

    localparam int DEF_MAX_OUT_WIDTH = 256;
    localparam int DEF_MAX_CHANNELS  = 64;
    localparam int DEF_MAX_POOL      = 8;
    localparam int DEF_MAX_IN_DIM    = 512;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int SAMPLE_W   = 32;
    localparam int IH_W = 10;
    localparam int IW_W = 10;
    localparam int CH_W = 7;
    localparam int OH_W = 10;
    localparam int OW_W = 9;
    localparam int PR_W = 4;
    localparam int PC_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT  = 3'd0,
        REG_IN_WIDTH   = 3'd1,
        REG_CHANNELS   = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_OUT_WIDTH  = 3'd4,
        REG_POOL_ROWS  = 3'd5,
        REG_POOL_COLS  = 3'd6
    } t_reg_idx;

    // Per-word flags handed from the position counters to the buffer stage
    typedef struct packed {
        logic act;    // word lands inside an emitted window
        logic first;  // first word of its window
        logic last;   // last word of its window
        logic fend;   // last output word of the map
    } t_req;

    // IEEE a > b: NaN never compares greater, -0 equals +0
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan, a_zero, b_zero;
        logic res;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_zero && b_zero)) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = !a[31];
        end else if (!a[31]) begin
            res = a[30:0] > b[30:0];
        end else begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### design/mxp_ctrl.sv
// Configuration registers and input position counters for the max pooling block.
`default_nettype none
module mxp_ctrl #(
    parameter int MAX_OUT_WIDTH = mxp_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_CHANNELS  = mxp_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_POOL      = mxp_pkg::DEF_MAX_POOL,
    parameter int MAX_IN_DIM    = mxp_pkg::DEF_MAX_IN_DIM,
    parameter int AW            = 14
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mxp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mxp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_accept,
    output mxp_pkg::t_req                        o_req,
    output logic [AW-1:0]                        o_idx
);
    import mxp_pkg::*;

    localparam int RW  = $clog2(MAX_IN_DIM + 1);
    localparam int CHW = $clog2(MAX_CHANNELS + 1);
    localparam int PW  = $clog2(MAX_POOL + 1);
    localparam int WCW = $clog2(MAX_OUT_WIDTH + 1);
    localparam int PRW = IH_W + PR_W;

    logic [IH_W-1:0] r_ih;
    logic [IW_W-1:0] r_iw;
    logic [CH_W-1:0] r_ch;
    logic [OH_W-1:0] r_oh;
    logic [OW_W-1:0] r_ow;
    logic [PR_W-1:0] r_pr;
    logic [PC_W-1:0] r_pc;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih <= IH_W'(2);
            r_iw <= IW_W'(2);
            r_ch <= CH_W'(1);
            r_oh <= OH_W'(1);
            r_ow <= OW_W'(1);
            r_pr <= PR_W'(2);
            r_pc <= PC_W'(2);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_IN_HEIGHT:  r_ih <= i_cfg_data[IH_W-1:0];
                REG_IN_WIDTH:   r_iw <= i_cfg_data[IW_W-1:0];
                REG_CHANNELS:   r_ch <= i_cfg_data[CH_W-1:0];
                REG_OUT_HEIGHT: r_oh <= i_cfg_data[OH_W-1:0];
                REG_OUT_WIDTH:  r_ow <= i_cfg_data[OW_W-1:0];
                REG_POOL_ROWS:  r_pr <= i_cfg_data[PR_W-1:0];
                REG_POOL_COLS:  r_pc <= i_cfg_data[PC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp each register to its legal range
    logic [IH_W-1:0] ih;
    logic [IW_W-1:0] iw;
    logic [CH_W-1:0] ch;
    logic [OH_W-1:0] oh;
    logic [OW_W-1:0] ow;
    logic [PR_W-1:0] pr;
    logic [PC_W-1:0] pc;

    always_comb begin
        ih = (r_ih == '0) ? IH_W'(1) : ((32'(r_ih) > MAX_IN_DIM) ? IH_W'(MAX_IN_DIM) : r_ih);
        iw = (r_iw == '0) ? IW_W'(1) : ((32'(r_iw) > MAX_IN_DIM) ? IW_W'(MAX_IN_DIM) : r_iw);
        ch = (r_ch == '0) ? CH_W'(1) :
             ((32'(r_ch) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : r_ch);
        oh = (r_oh == '0) ? OH_W'(1) : ((32'(r_oh) > MAX_IN_DIM) ? OH_W'(MAX_IN_DIM) : r_oh);
        ow = (r_ow == '0) ? OW_W'(1) :
             ((32'(r_ow) > MAX_OUT_WIDTH) ? OW_W'(MAX_OUT_WIDTH) : r_ow);
        pr = (r_pr == '0) ? PR_W'(1) : ((32'(r_pr) > MAX_POOL) ? PR_W'(MAX_POOL) : r_pr);
        pc = (r_pc == '0) ? PC_W'(1) : ((32'(r_pc) > MAX_POOL) ? PC_W'(MAX_POOL) : r_pc);
    end

    logic [RW-1:0]  r_row, n_row;
    logic [RW-1:0]  r_col, n_col;
    logic [CHW-1:0] r_chan, n_chan;
    logic [PW-1:0]  r_riw, n_riw;
    logic [PW-1:0]  r_ciw, n_ciw;
    logic [WCW-1:0] r_wcol, n_wcol;

    logic [PRW-1:0] rows_used;
    logic [PRW-1:0] cols_used;

    // classify the current position
    always_comb begin
        rows_used   = PRW'(oh) * PRW'(pr);
        cols_used   = PRW'(ow) * PRW'(pc);
        o_req.act   = (PRW'(r_row) < rows_used) && (PRW'(r_col) < cols_used) &&
                      (32'(r_wcol) < 32'(ow));
        o_req.first = (r_riw == '0) && (r_ciw == '0);
        o_req.last  = (32'(r_riw) == 32'(pr) - 1) && (32'(r_ciw) == 32'(pc) - 1);
        o_req.fend  = (PRW'(r_row) == rows_used - PRW'(1)) &&
                      (32'(r_wcol) == 32'(ow) - 1) && (32'(r_chan) == 32'(ch) - 1);
        o_idx       = AW'(32'(r_wcol) * MAX_CHANNELS + 32'(r_chan));
    end

    // advance the position on each accepted word
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_chan = r_chan + CHW'(1);
        n_riw  = r_riw;
        n_ciw  = r_ciw;
        n_wcol = r_wcol;
        if (32'(n_chan) >= 32'(ch)) begin
            n_chan = '0;
            n_ciw  = r_ciw + PW'(1);
            if (32'(n_ciw) >= 32'(pc)) begin
                n_ciw  = '0;
                // never passes the column count, so it fits its width
                n_wcol = r_wcol + WCW'(1);
            end
            n_col = r_col + RW'(1);
            if (32'(n_col) >= 32'(iw)) begin
                n_col  = '0;
                n_ciw  = '0;
                n_wcol = '0;
                n_riw  = r_riw + PW'(1);
                if (32'(n_riw) >= 32'(pr)) begin
                    n_riw = '0;
                end
                n_row = r_row + RW'(1);
                if (32'(n_row) >= 32'(ih)) begin
                    n_row = '0;
                    n_riw = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_chan <= '0;
            r_riw  <= '0;
            r_ciw  <= '0;
            r_wcol <= '0;
        end else if (i_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_chan <= n_chan;
            r_riw  <= n_riw;
            r_ciw  <= n_ciw;
            r_wcol <= n_wcol;
        end
    end

endmodule
`default_nettype wire

### design/mxp_buf.sv
// Partial maximum memory with read, compare and write-back stage.
`default_nettype none
module mxp_buf #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  mxp_pkg::t_req                      i_req,
    input  wire logic [AW-1:0]                 i_idx,
    input  wire logic [mxp_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_adv,
    output logic                               o_valid,
    output logic                               o_emit,
    output logic                               o_fend,
    output logic [mxp_pkg::SAMPLE_W-1:0]       o_value
);
    import mxp_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_fwd_val;
    logic                r_fwd;
    logic                r_valid;
    t_req                r_req;
    logic [AW-1:0]       r_idx;

    logic [SAMPLE_W-1:0] old_val;
    logic [SAMPLE_W-1:0] new_val;

    // merge the word into the stored maximum; forward a write still in flight
    always_comb begin
        old_val = r_fwd ? r_fwd_val : r_rdata;
        new_val = (r_req.first || fp_gt(r_sample, old_val)) ? r_sample : old_val;
        o_valid = r_valid;
        o_emit  = r_req.act && r_req.last;
        o_fend  = r_req.fend;
        o_value = new_val;
    end

    // memory read on accept, write back when the stage retires
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= r_mem[i_idx];
        end
        if (r_valid && r_req.act && i_adv) begin
            r_mem[r_idx] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample  <= i_sample;
            r_req     <= i_req;
            r_idx     <= i_idx;
            r_fwd     <= r_valid && r_req.act && (r_idx == i_idx);
            r_fwd_val <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_accept;
        end
    end

endmodule
`default_nettype wire

### design/max_pool_2d_hwc.sv
// Top level of the streaming non-overlapping 2-D max pooling block.
// Takes one fp32 word per cycle in height, width, channel order and emits each window
// maximum from an output register after the buffer stage, so a new word is taken every cycle
// while the output side keeps up. The rate is set by the single read-modify-write pass per
// word through the partial maximum memory (one read port, one write port, registered read);
// a word that lands in the same entry as the one ahead of it takes the forwarded value.
// Write configuration only while the block is idle; the block does not enforce this.
`default_nettype none
module max_pool_2d_hwc #(
    parameter int MAX_OUT_WIDTH = mxp_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_CHANNELS  = mxp_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_POOL      = mxp_pkg::DEF_MAX_POOL,
    parameter int MAX_IN_DIM    = mxp_pkg::DEF_MAX_IN_DIM
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mxp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mxp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [mxp_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [mxp_pkg::SAMPLE_W-1:0]         o_pooled,
    output logic                                 o_frame_end
);
    import mxp_pkg::*;

    localparam int DEPTH = MAX_OUT_WIDTH * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_req                req;
    logic [AW-1:0]       idx;
    logic                accept;
    logic                adv;
    logic                s1_valid, s1_emit, s1_fend;
    logic [SAMPLE_W-1:0] s1_value;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_fend;

    mxp_ctrl #(
        .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_POOL     (MAX_POOL),
        .MAX_IN_DIM   (MAX_IN_DIM),
        .AW           (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept  (accept),
        .o_req     (req),
        .o_idx     (idx)
    );

    mxp_buf #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_req   (req),
        .i_idx   (idx),
        .i_sample(i_sample),
        .i_adv   (adv),
        .o_valid (s1_valid),
        .o_emit  (s1_emit),
        .o_fend  (s1_fend),
        .o_value (s1_value)
    );

    // the stage retires unless its result finds the output register blocked
    always_comb begin
        adv         = !s1_valid || !s1_emit || !r_out_valid || i_ready;
        o_ready     = adv;
        accept      = i_valid && adv;
        o_valid     = r_out_valid;
        o_pooled    = r_out_data;
        o_frame_end = r_out_fend;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_valid && s1_emit && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_valid && s1_emit && adv) begin
            r_out_data <= s1_value;
            r_out_fend <= s1_fend;
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the streaming non-overlapping 2-D max pooling block.
`default_nettype none
module tb;
    import mxp_pkg::*;

    localparam int NREG = 7;
    localparam int BUF_N = DEF_MAX_OUT_WIDTH * DEF_MAX_CHANNELS;
    localparam int SETTLE = 10;

    typedef struct {
        logic [31:0] pooled;
        logic        fend;
    } t_pool_res;

    typedef struct {
        logic [31:0] sample;
        bit          typed;
        logic [31:0] pooled;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [SAMPLE_W-1:0]   o_pooled;
    logic                  o_frame_end;

    max_pool_2d_hwc u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    int unsigned cfg_val [NREG];
    int unsigned cfg_mask [NREG] = '{32'h3FF, 32'h3FF, 32'h7F, 32'h3FF, 32'h1FF, 32'hF, 32'hF};
    logic [31:0] win_max [BUF_N];
    int unsigned row_n, col_n, chan_n, row_w, col_w, wcol;

    t_pool_res pool_q [$];
    int errs = 0;
    int idle_mode = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // IEEE greater-than via a monotonic integer key
    function automatic bit flt_above(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka, kb;
        if ((&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0])) return 0;
        if (a[30:0] == 0 && b[30:0] == 0) return 0;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        return ka > kb;
    endfunction

    function automatic int unsigned frame_words();
        return clampv(cfg_val[REG_IN_HEIGHT], DEF_MAX_IN_DIM)
             * clampv(cfg_val[REG_IN_WIDTH], DEF_MAX_IN_DIM)
             * clampv(cfg_val[REG_CHANNELS], DEF_MAX_CHANNELS);
    endfunction

    // advance the pooling position by one word; returns 1 when a window closes
    task automatic pool_step(input logic [31:0] s, output bit got, output t_pool_res r);
        int unsigned ih, iw, ch, oh, ow, pr, pc, idx;
        bit first, last;
        ih = clampv(cfg_val[REG_IN_HEIGHT], DEF_MAX_IN_DIM);
        iw = clampv(cfg_val[REG_IN_WIDTH], DEF_MAX_IN_DIM);
        ch = clampv(cfg_val[REG_CHANNELS], DEF_MAX_CHANNELS);
        oh = clampv(cfg_val[REG_OUT_HEIGHT], DEF_MAX_IN_DIM);
        ow = clampv(cfg_val[REG_OUT_WIDTH], DEF_MAX_OUT_WIDTH);
        pr = clampv(cfg_val[REG_POOL_ROWS], DEF_MAX_POOL);
        pc = clampv(cfg_val[REG_POOL_COLS], DEF_MAX_POOL);
        got = 0;
        if (row_n < oh * pr && col_n < ow * pc && wcol < ow) begin
            idx = (wcol % DEF_MAX_OUT_WIDTH) * DEF_MAX_CHANNELS + (chan_n % DEF_MAX_CHANNELS);
            first = (row_w == 0) && (col_w == 0);
            last = (row_w == pr - 1) && (col_w == pc - 1);
            if (first || flt_above(s, win_max[idx])) win_max[idx] = s;
            if (last) begin
                got = 1;
                r.pooled = win_max[idx];
                r.fend = (row_n == oh * pr - 1) && (wcol == ow - 1) && (chan_n == ch - 1);
            end
        end
        chan_n++;
        if (chan_n >= ch) begin
            chan_n = 0;
            col_w++;
            if (col_w >= pc) begin
                col_w = 0;
                wcol++;
            end
            col_n++;
            if (col_n >= iw) begin
                col_n = 0;
                col_w = 0;
                wcol = 0;
                row_w++;
                if (row_w >= pr) row_w = 0;
                row_n++;
                if (row_n >= ih) begin
                    row_n = 0;
                    row_w = 0;
                end
            end
        end
    endtask

    // offer one word, wait for the handshake; returns the predicted window result
    task automatic send_word(input logic [31:0] s, output bit got, output t_pool_res r);
        int pct;
        pct = (idle_mode == 1) ? 58 : ((idle_mode == 3) ? 33 : 0);
        // each idle cycle drawn on its own, so the idle share matches pct
        while ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        pool_step(s, got, r);
    endtask

    task automatic push_word(input logic [31:0] s);
        bit got;
        t_pool_res r;
        send_word(s, got, r);
        if (got) pool_q.push_back(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pool_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int unsigned v [NREG]);
        for (int k = 0; k < NREG; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_reg_idx'(k);
            i_cfg_data <= v[k][CFG_DATA_W-1:0];
            @(posedge i_clk);
            cfg_val[k] = v[k] & cfg_mask[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    // random content with a share of zeros, infinities, NaNs and values of magnitude one to sixteen
    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v = {v[31], 31'd0};
            1: v = {v[31], 8'hFF, 23'd0};
            2: v = {v[31], 8'hFF, v[22:0] | 23'd1};
            3: v = {v[31], 8'd127 + 8'($urandom_range(0, 3)), v[22:0]};
            default: ;
        endcase
        return v;
    endfunction

    // output side: checks each word and paces i_ready
    always @(posedge i_clk) begin
        t_pool_res e;
        if (o_valid && i_ready) begin
            if (pool_q.size() == 0) begin
                $error("unexpected word pooled=%h frame_end=%b", o_pooled, o_frame_end);
                errs++;
            end else begin
                e = pool_q.pop_front();
                if (o_pooled !== e.pooled) begin
                    $error("pooled expected %h actual %h", e.pooled, o_pooled);
                    errs++;
                end
                if (o_frame_end !== e.fend) begin
                    $error("frame_end expected %b actual %b", e.fend, o_frame_end);
                    errs++;
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 1'b0;
        end else if (idle_mode == 2) i_ready <= ($urandom_range(99) >= 58);
        else if (idle_mode == 3) i_ready <= ($urandom_range(99) >= 33);
        else i_ready <= 1'b1;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    // directed words under the reset setting: 2x2 window, one output per four words
    t_dir_row dir_tab [20] = '{
        '{32'h0000_0000, 0, 0}, '{32'h8000_0000, 0, 0},
        '{32'h0000_0000, 0, 0}, '{32'h8000_0000, 1, 32'h0000_0000},
        '{32'h8000_0000, 0, 0}, '{32'h0000_0000, 0, 0},
        '{32'h0000_0000, 0, 0}, '{32'h0000_0000, 1, 32'h8000_0000},
        '{32'h7FC0_0000, 0, 0}, '{32'h3F80_0000, 0, 0},
        '{32'h7F80_0000, 0, 0}, '{32'h0000_0001, 1, 32'h7FC0_0000},
        '{32'hBF80_0000, 0, 0}, '{32'h7FFF_FFFF, 0, 0},
        '{32'hC000_0000, 0, 0}, '{32'h3F80_0000, 1, 32'h3F80_0000},
        '{32'hFF80_0000, 0, 0}, '{32'hFFFF_FFFF, 0, 0},
        '{32'h7F7F_FFFF, 0, 0}, '{32'h0080_0000, 1, 32'h7F7F_FFFF}
    };

    // extreme settings: in_h, in_w, ch, out_h, out_w, pool_r, pool_c
    int unsigned ext_cfg [8][NREG] = '{
        '{0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, 1023, 511, 1, 1},
        '{1, 1, 127, 1, 1, 1, 1},
        '{1, 2, 127, 1, 1, 1, 2},
        '{2, 2, 1, 1, 1, 15, 15},
        '{8, 8, 1, 1, 1, 8, 8},
        '{5, 7, 2, 2, 3, 2, 2},
        '{2, 4, 2, 2, 2, 2, 2}
    };

    initial begin
        bit got;
        t_pool_res r;
        int unsigned rc [NREG];
        int unsigned oh, ow, pr, pc, nw;
        int rand_cnt, phase;

        cfg_val = '{2, 2, 1, 1, 1, 2, 2};
        row_n = 0; col_n = 0; chan_n = 0; row_w = 0; col_w = 0; wcol = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tab[k]) begin
            send_word(dir_tab[k].sample, got, r);
            if (got) pool_q.push_back(dir_tab[k].typed ? t_pool_res'{dir_tab[k].pooled, 1'b1} : r);
        end
        drain();

        // extremes of the registers, one whole frame each
        foreach (ext_cfg[p]) begin
            idle_mode = p % 4;
            write_cfg(ext_cfg[p]);
            nw = frame_words();
            repeat (nw) push_word(rand_sample());
            drain();
        end

        // random small settings, each a few whole frames
        rand_cnt = 0;
        phase = 0;
        while (rand_cnt < 120 || phase < 4) begin
            idle_mode = phase % 4;
            // the long receiver hold uses 1x1 windows so every word inside the pooled area yields a result
            pr = (phase == 2) ? 1 : $urandom_range(1, 3);
            pc = (phase == 2) ? 1 : $urandom_range(1, 3);
            oh = $urandom_range(1, 2);
            ow = $urandom_range(1, 3);
            rc[REG_POOL_ROWS] = pr;
            rc[REG_POOL_COLS] = pc;
            rc[REG_OUT_HEIGHT] = oh;
            rc[REG_OUT_WIDTH] = ow;
            rc[REG_CHANNELS] = $urandom_range(1, 3);
            rc[REG_IN_HEIGHT] = oh * pr + $urandom_range(0, 1);
            rc[REG_IN_WIDTH] = ow * pc + $urandom_range(0, 1);
            // now and then one more output row, which the input mostly leaves incomplete
            if ($urandom_range(7) == 0) rc[REG_OUT_HEIGHT] = oh + 1;
            write_cfg(rc);
            if (phase == 2) hold_req = 1'b1;
            nw = frame_words() * ((phase == 2) ? 3 : $urandom_range(1, 2));
            repeat (nw) push_word(rand_sample());
            rand_cnt += nw;
            drain();
            phase++;
        end

        if (errs == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
